// ----- rtl/dsrd_pkg.sv -----
// Shared types, command codes and arithmetic helpers for the dual stepper ramp driver.
// No dependencies.
`timescale 1ns / 1ps

package dsrd_pkg;

   localparam logic [1:0] CMD_TICK    = 2'd0;
   localparam logic [1:0] CMD_FORWARD = 2'd1;
   localparam logic [1:0] CMD_ROTATE  = 2'd2;
   localparam logic [1:0] CMD_READ    = 2'd3;

   localparam logic [9:0] THRESHOLD_RESET = 10'd100;
   localparam logic signed [10:0] SPEED_LIMIT = 11'sd100;

   typedef struct packed {
      logic tick;
      logic clear;
   } motor_ctrl_type;

   typedef struct packed {
      logic [3:0]         coils;
      logic signed [15:0] count;
   } motor_status_type;

   // half-step coil sequence
   function automatic logic [3:0] half_step_coils(input logic [2:0] phase);
      logic [3:0] c;
      case (phase)
         3'd0: c = 4'd1;
         3'd1: c = 4'd3;
         3'd2: c = 4'd2;
         3'd3: c = 4'd6;
         3'd4: c = 4'd4;
         3'd5: c = 4'd12;
         3'd6: c = 4'd8;
         3'd7: c = 4'd9;
         default: c = 4'd0;
      endcase
      return c;
   endfunction

   // divide by ten, truncated toward zero; |v| <= 1024 via reciprocal 205/2048
   function automatic logic signed [7:0] div10(input logic signed [10:0] v);
      logic [10:0] mag;
      logic [18:0] prod;
      logic [7:0]  q;
      mag  = v[10] ? 11'(-v) : 11'(v);
      prod = 19'(mag) * 19'd205;
      q    = prod[18:11];
      return v[10] ? -$signed(q) : $signed(q);
   endfunction

   function automatic logic signed [7:0] clamp100(input logic signed [10:0] v);
      logic signed [10:0] c;
      if (v > SPEED_LIMIT) begin
         c = SPEED_LIMIT;
      end else if (v < -SPEED_LIMIT) begin
         c = -SPEED_LIMIT;
      end else begin
         c = v;
      end
      return c[7:0];
   endfunction

   function automatic logic signed [10:0] times10(input logic signed [7:0] v);
      logic signed [10:0] w;
      w = 11'(v);
      return (w <<< 3) + (w <<< 1);
   endfunction

endpackage

// ----- rtl/dsrd_motor.sv -----
// One motor channel: speed ramp, step accumulator, half-step phase and odometry.
// Depends on dsrd_pkg.
`timescale 1ns / 1ps

module dsrd_motor (
   input  logic                       clock,
   input  logic                       reset,
   input  dsrd_pkg::motor_ctrl_type   ctrl,
   input  logic signed [10:0]         target,
   input  logic [9:0]                 threshold,
   output dsrd_pkg::motor_status_type status
);
   import dsrd_pkg::*;

   logic signed [10:0] actual_ff, actual_in;
   logic signed [11:0] acc_ff, acc_in;
   logic [2:0]         phase_ff, phase_in;
   logic signed [15:0] count_ff, count_in;
   logic [3:0]         coils_ff, coils_in;

   logic signed [13:0] acc_sum;
   logic signed [13:0] thr;
   logic signed [13:0] acc_adj;
   logic signed [7:0]  delta;

   always_comb begin
      actual_in = (actual_ff < target) ? actual_ff + 11'sd1 : target;
      delta     = div10(actual_in);
      acc_sum   = 14'(acc_ff) + 14'(delta);
      thr       = $signed({4'd0, threshold});
      acc_adj   = acc_sum;
      phase_in  = phase_ff;
      count_in  = count_ff;
      coils_in  = coils_ff;
      if (acc_sum >= thr) begin
         acc_adj  = acc_sum - thr;
         phase_in = phase_ff + 3'd1;
         count_in = count_ff + 16'sd1;
         coils_in = half_step_coils(phase_in);
      end else if (acc_sum <= -thr) begin
         acc_adj  = acc_sum + thr;
         phase_in = phase_ff - 3'd1;
         count_in = count_ff - 16'sd1;
         coils_in = half_step_coils(phase_in);
      end
      acc_in = acc_adj[11:0];
   end

   // result view: after this item's step, before any clear
   always_comb begin
      if (ctrl.tick) begin
         status.coils = coils_in;
         status.count = count_in;
      end else begin
         status.coils = coils_ff;
         status.count = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         actual_ff <= '0;
         acc_ff    <= '0;
         phase_ff  <= '0;
         count_ff  <= '0;
         coils_ff  <= '0;
      end else if (ctrl.tick) begin
         actual_ff <= actual_in;
         acc_ff    <= acc_in;
         phase_ff  <= phase_in;
         count_ff  <= count_in;
         coils_ff  <= coils_in;
      end else if (ctrl.clear) begin
         count_ff  <= '0;
      end
   end

endmodule

// ----- rtl/dual_stepper_ramp_driver.sv -----
// Top level of the dual stepper ramp driver: input register, command decode, target
// speeds, two motor channels and the result register. Depends on dsrd_pkg, dsrd_motor.
`timescale 1ns / 1ps

// Each item (tick, forward, rotate, read-and-clear) returns exactly one result item
// with both coil drives and both odometry counts. An item lands in an input register,
// is processed combinationally against the motor state and goes to a result
// register; the block takes one item per cycle while intake is not stalled. A held
// result only stalls intake once the input register is also occupied. The user must
// write the threshold thr_ff via csr_wr_en/csr_wr_data while idle; the block does not check it.
module dual_stepper_ramp_driver (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_cmd,
   input  logic signed [8:0]  req_speed,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [3:0]         rsp_coils_left,
   output logic [3:0]         rsp_coils_right,
   output logic signed [15:0] rsp_odometry_left,
   output logic signed [15:0] rsp_odometry_right,
   input  logic               csr_wr_en,
   input  logic [9:0]         csr_wr_data
);
   import dsrd_pkg::*;

   logic               in_valid_ff, in_valid_in;
   logic [1:0]         in_cmd_ff;
   logic signed [8:0]  in_speed_ff;
   logic               out_valid_ff, out_valid_in;
   logic [3:0]         out_coils_l_ff, out_coils_r_ff;
   logic signed [15:0] out_odo_l_ff, out_odo_r_ff;
   logic [9:0]         thr_ff;
   logic signed [10:0] target_l_ff, target_r_ff, target_l_in, target_r_in;

   logic               accept;
   logic               advance;
   logic signed [11:0] sum_t;
   logic signed [11:0] half_sum;
   logic signed [7:0]  mean;
   motor_ctrl_type     ctrl;
   motor_status_type   status_l, status_r;

   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   assign in_valid_in  = accept ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign out_valid_in = advance ? 1'b1 : (rsp_stall ? out_valid_ff : 1'b0);

   always_comb begin
      sum_t       = 12'(target_l_ff) + 12'(target_r_ff);
      half_sum    = sum_t + $signed({11'd0, sum_t[11]});
      mean        = div10(half_sum[11:1]);
      target_l_in = target_l_ff;
      target_r_in = target_r_ff;
      case (in_cmd_ff)
         CMD_FORWARD: begin
            target_l_in = times10(clamp100(11'(in_speed_ff)));
            target_r_in = target_l_in;
         end
         CMD_ROTATE: begin
            target_l_in = times10(clamp100(11'(mean) + 11'(in_speed_ff)));
            target_r_in = times10(clamp100(11'(mean) - 11'(in_speed_ff)));
         end
         default: begin
         end
      endcase
      ctrl.tick  = advance && (in_cmd_ff == CMD_TICK);
      ctrl.clear = advance && (in_cmd_ff == CMD_READ);
   end

   dsrd_motor u_motor_left (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .target    (target_l_ff),
      .threshold (thr_ff),
      .status    (status_l)
   );

   dsrd_motor u_motor_right (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .target    (target_r_ff),
      .threshold (thr_ff),
      .status    (status_r)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         thr_ff       <= THRESHOLD_RESET;
         target_l_ff  <= '0;
         target_r_ff  <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_wr_en) begin
            thr_ff <= csr_wr_data;
         end
         if (advance) begin
            target_l_ff <= target_l_in;
            target_r_ff <= target_r_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_cmd_ff   <= req_cmd;
         in_speed_ff <= req_speed;
      end
      if (advance) begin
         out_coils_l_ff <= status_l.coils;
         out_coils_r_ff <= status_r.coils;
         out_odo_l_ff   <= status_l.count;
         out_odo_r_ff   <= status_r.count;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_coils_left     = out_coils_l_ff;
   assign rsp_coils_right    = out_coils_r_ff;
   assign rsp_odometry_left  = out_odo_l_ff;
   assign rsp_odometry_right = out_odo_r_ff;

   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && out_valid_ff && rsp_stall))
      else $error("intake stalled without a held item");

   a_target_range: assert property (@(posedge clock) disable iff (reset)
      (target_l_ff <= 11'sd1000) && (target_l_ff >= -11'sd1000) &&
      (target_r_ff <= 11'sd1000) && (target_r_ff >= -11'sd1000))
      else $error("target speed out of range");

   a_read_clears: assert property (@(posedge clock) disable iff (reset)
      ctrl.clear |=> ctrl.tick || ((status_l.count == 16'sd0) && (status_r.count == 16'sd0)))
      else $error("odometry not cleared after read");

   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid)
      else $error("processed item produced no result");

endmodule
